/* src/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg
// Types, register indexes and the tone reload table used by the buzzer
// melody sequencer.
// ----------------------------------------------------------------------------
package bms_pkg;

   localparam int NOTE_DEPTH    = 256;
   localparam int NOTE_AW       = $clog2(NOTE_DEPTH);
   localparam int TONE_COUNT    = 21;
   localparam int COUNTER_WIDTH = 16;
   localparam int ENTRY_WIDTH   = 13;

   // request modes
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_CHANGE = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_START_SONG_ONE   = 3'd0;
   localparam logic [2:0] CSR_START_SONG_TWO   = 3'd1;
   localparam logic [2:0] CSR_START_SONG_THREE = 3'd2;
   localparam logic [2:0] CSR_START_SONG_FOUR  = 3'd3;
   localparam logic [2:0] CSR_TICKS_PER_UNIT   = 3'd4;
   localparam logic [2:0] CSR_GAP_UNITS        = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_NOTE = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] song_pins;
      logic [7:0] entry_address;
      logic [4:0] entry_tone;
      logic [7:0] entry_duration;
   } req_type;

   typedef struct packed {
      logic       buzzer_level;
      logic       tone_running;
      logic [2:0] current_song;
      logic [7:0] note_pointer;
   } rsp_type;

   typedef struct packed {
      phase_type                phase;
      logic [2:0]               song_number;
      logic [NOTE_AW-1:0]       pointer;
      logic [7:0]               units_left;
      logic [31:0]              unit_ticks;
      logic [COUNTER_WIDTH-1:0] tone_counter;
      logic [COUNTER_WIDTH-1:0] reload_value;
      logic                     counter_on;
      logic                     buzzer;
      logic                     change_pending;
   } seq_state_type;

   // reload values of the c-scale tones, tone 1 at index 0
   function automatic logic [COUNTER_WIDTH-1:0] tone_reload(input logic [4:0] idx);
      logic [COUNTER_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = COUNTER_WIDTH'(62018);
         5'd1:    val = COUNTER_WIDTH'(62401);
         5'd2:    val = COUNTER_WIDTH'(62743);
         5'd3:    val = COUNTER_WIDTH'(62903);
         5'd4:    val = COUNTER_WIDTH'(63185);
         5'd5:    val = COUNTER_WIDTH'(63441);
         5'd6:    val = COUNTER_WIDTH'(63670);
         5'd7:    val = COUNTER_WIDTH'(63777);
         5'd8:    val = COUNTER_WIDTH'(63969);
         5'd9:    val = COUNTER_WIDTH'(64140);
         5'd10:   val = COUNTER_WIDTH'(64216);
         5'd11:   val = COUNTER_WIDTH'(64360);
         5'd12:   val = COUNTER_WIDTH'(64489);
         5'd13:   val = COUNTER_WIDTH'(64603);
         5'd14:   val = COUNTER_WIDTH'(64655);
         5'd15:   val = COUNTER_WIDTH'(64751);
         5'd16:   val = COUNTER_WIDTH'(64837);
         5'd17:   val = COUNTER_WIDTH'(64876);
         5'd18:   val = COUNTER_WIDTH'(64948);
         5'd19:   val = COUNTER_WIDTH'(65012);
         5'd20:   val = COUNTER_WIDTH'(65070);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* src/buzzer_melody_sequencer_top.sv */
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer_top
// Square-wave melody player: note store, song sequencing and tone counter.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the response side stalls, and returns
// one response per request via the input stage and response register. A tick
// request advances the tone counter and the note sequencer by one step; a
// write request fills one note store entry; a change request makes the song
// stop after its current note and gap. The note store is a RAM read when a
// request is accepted, at the address that request may load from, so the
// sequencer step itself sees the entry at once; a write by the request just
// ahead is forwarded. The note store has no reset and needs no clearing pass:
// every entry a song reaches must be written first. The configuration port
// is always ready; write it only while no requests are in flight.
module buzzer_melody_sequencer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bms_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam int AW = bms_pkg::NOTE_AW;
   localparam int EW = bms_pkg::ENTRY_WIDTH;

   localparam logic [bms_pkg::COUNTER_WIDTH-1:0] COUNTER_WIDTH_ONE =
      bms_pkg::COUNTER_WIDTH'(1);

   // configuration
   logic [7:0]  start_ff [4];
   logic [31:0] tpu_ff;
   logic [7:0]  gap_ff;

   // input stage
   logic             a_valid_ff;
   bms_pkg::req_type a_item_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic             fwd_hit_ff;
   logic [EW-1:0]    fwd_data_ff;

   // sequencer state and response register
   bms_pkg::seq_state_type st_ff, st_in, st_next;
   logic             rsp_valid_ff;
   bms_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          req_accept, a_moves;
   logic [AW-1:0] rd_addr_in, ram_rd_addr;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data, ram_rd_data;

   assign csr_ready  = 1'b1;
   assign a_moves    = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !a_valid_ff || a_moves;
   assign req_accept = req_valid && req_ready;

   function automatic logic [1:0] first_pin(input logic [3:0] pins);
      logic [1:0] idx;
      if (pins[0]) begin
         idx = 2'd0;
      end else if (pins[1]) begin
         idx = 2'd1;
      end else if (pins[2]) begin
         idx = 2'd2;
      end else begin
         idx = 2'd3;
      end
      return idx;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff[0] <= 8'd0;
         start_ff[1] <= 8'd64;
         start_ff[2] <= 8'd128;
         start_ff[3] <= 8'd192;
         tpu_ff      <= 32'd1000000;
         gap_ff      <= 8'd2;
      end else if (csr_valid) begin
         case (csr_index)
            bms_pkg::CSR_START_SONG_ONE:   start_ff[0] <= csr_data[7:0];
            bms_pkg::CSR_START_SONG_TWO:   start_ff[1] <= csr_data[7:0];
            bms_pkg::CSR_START_SONG_THREE: start_ff[2] <= csr_data[7:0];
            bms_pkg::CSR_START_SONG_FOUR:  start_ff[3] <= csr_data[7:0];
            bms_pkg::CSR_TICKS_PER_UNIT:   tpu_ff      <= csr_data;
            bms_pkg::CSR_GAP_UNITS:        gap_ff      <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // note store write happens as the write request leaves the input stage
   assign ram_wr_en   = a_moves && (a_item_ff.mode == bms_pkg::MODE_WRITE) &&
                        (32'(a_item_ff.entry_address) < bms_pkg::NOTE_DEPTH);
   assign ram_wr_addr = AW'(a_item_ff.entry_address);
   assign ram_wr_data = {a_item_ff.entry_tone, a_item_ff.entry_duration};

   assign st_next = a_moves ? st_in : st_ff;

   // address the incoming request may load, given the state it will see
   always_comb begin
      case (st_next.phase)
         bms_pkg::PH_IDLE: rd_addr_in = AW'(start_ff[first_pin(req_data.song_pins)]);
         bms_pkg::PH_NOTE: rd_addr_in = st_next.pointer + AW'(1);
         bms_pkg::PH_GAP:  rd_addr_in = AW'(start_ff[st_next.song_number[1:0] - 2'd1]);
         default:          rd_addr_in = st_next.pointer;
      endcase
   end

   assign ram_rd_addr = req_accept ? rd_addr_in : rd_addr_ff;

   bms_ram #(
      .WIDTH (EW),
      .DEPTH (bms_pkg::NOTE_DEPTH)
   ) u_note_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_moves) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_item_ff   <= req_data;
         rd_addr_ff  <= rd_addr_in;
         fwd_hit_ff  <= ram_wr_en && (ram_wr_addr == rd_addr_in);
         fwd_data_ff <= ram_wr_data;
      end
   end

   // sequencer step for the request leaving the input stage
   always_comb begin : seq_next
      logic [EW-1:0] entry;
      logic [4:0]    e_tone;
      logic [7:0]    e_dur;
      logic [31:0]   tick_sum;
      logic          unit_done;
      logic [7:0]    units_dec;
      logic          last_unit;
      logic          do_load;
      logic          do_gap;
      logic          gap_over;
      logic [1:0]    pin_idx;
      entry     = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
      e_tone    = entry[12:8];
      e_dur     = entry[7:0];
      tick_sum  = st_ff.unit_ticks + 32'd1;
      unit_done = (tick_sum >= tpu_ff);
      units_dec = (st_ff.units_left != 8'd0) ? st_ff.units_left - 8'd1 : st_ff.units_left;
      last_unit = unit_done && (units_dec == 8'd0);
      pin_idx   = first_pin(a_item_ff.song_pins);
      do_load   = 1'b0;
      do_gap    = 1'b0;
      gap_over  = 1'b0;
      st_in     = st_ff;
      case (a_item_ff.mode)
         bms_pkg::MODE_TICK: begin
            if (st_ff.counter_on) begin
               if (st_ff.tone_counter == '1) begin
                  st_in.buzzer       = !st_ff.buzzer;
                  st_in.tone_counter = st_ff.reload_value;
               end else begin
                  st_in.tone_counter = st_ff.tone_counter + COUNTER_WIDTH_ONE;
               end
            end
            case (st_ff.phase)
               bms_pkg::PH_IDLE: begin
                  st_in.counter_on     = 1'b0;
                  st_in.song_number    = 3'd0;
                  st_in.change_pending = 1'b0;
                  if (a_item_ff.song_pins != 4'd0) begin
                     st_in.song_number = {1'b0, pin_idx} + 3'd1;
                     st_in.pointer     = AW'(start_ff[pin_idx]);
                     do_load           = 1'b1;
                  end
               end
               bms_pkg::PH_NOTE: begin
                  if (unit_done) begin
                     st_in.unit_ticks = 32'd0;
                     st_in.units_left = units_dec;
                     if (last_unit) begin
                        st_in.pointer = st_ff.pointer + AW'(1);
                        if (st_ff.change_pending) begin
                           do_gap = 1'b1;
                        end else begin
                           do_load = 1'b1;
                        end
                     end
                  end else begin
                     st_in.unit_ticks = tick_sum;
                  end
               end
               bms_pkg::PH_GAP: begin
                  if (st_ff.units_left == 8'd0) begin
                     gap_over = 1'b1;
                  end else if (unit_done) begin
                     st_in.unit_ticks = 32'd0;
                     st_in.units_left = units_dec;
                     gap_over         = last_unit;
                  end else begin
                     st_in.unit_ticks = tick_sum;
                  end
                  if (gap_over) begin
                     if (st_ff.change_pending) begin
                        st_in.phase          = bms_pkg::PH_IDLE;
                        st_in.song_number    = 3'd0;
                        st_in.change_pending = 1'b0;
                        st_in.counter_on     = 1'b0;
                     end else begin
                        st_in.pointer = AW'(start_ff[st_ff.song_number[1:0] - 2'd1]);
                        do_load       = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         bms_pkg::MODE_CHANGE: begin
            if (st_ff.phase != bms_pkg::PH_IDLE) begin
               st_in.change_pending = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // end-of-song entry goes straight to the gap
      if (do_load && (e_dur == 8'd0)) begin
         do_gap = 1'b1;
      end else if (do_load) begin
         if ((e_tone != 5'd0) && (32'(e_tone) <= bms_pkg::TONE_COUNT)) begin
            st_in.reload_value = bms_pkg::tone_reload(e_tone - 5'd1);
            st_in.tone_counter = bms_pkg::tone_reload(e_tone - 5'd1);
            st_in.counter_on   = 1'b1;
         end else begin
            st_in.counter_on = 1'b0;
         end
         st_in.phase      = bms_pkg::PH_NOTE;
         st_in.units_left = e_dur;
         st_in.unit_ticks = 32'd0;
      end
      if (do_gap) begin
         st_in.counter_on = 1'b0;
         st_in.phase      = bms_pkg::PH_GAP;
         st_in.units_left = gap_ff;
         st_in.unit_ticks = 32'd0;
      end
   end

   always_comb begin : rsp_out
      rsp_data_in.buzzer_level = st_in.buzzer;
      rsp_data_in.tone_running = st_in.counter_on;
      rsp_data_in.current_song = st_in.song_number;
      rsp_data_in.note_pointer = 8'(st_in.pointer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase          <= bms_pkg::PH_IDLE;
         st_ff.song_number    <= 3'd0;
         st_ff.pointer        <= '0;
         st_ff.units_left     <= 8'd0;
         st_ff.unit_ticks     <= 32'd0;
         st_ff.tone_counter   <= '0;
         st_ff.reload_value   <= '0;
         st_ff.counter_on     <= 1'b0;
         st_ff.buzzer         <= 1'b0;
         st_ff.change_pending <= 1'b0;
      end else if (a_moves) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_moves) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_moves) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/bms_ram.sv */
// ----------------------------------------------------------------------------
// bms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
